/* rtl/crc8fc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crc8fc_pkg
// Shared types, codes and the CRC-8 (poly 0x31) byte update.
// ----------------------------------------------------------------------------
package crc8fc_pkg;

  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_MSB  = 8'h80;

  localparam logic       KIND_PAYLOAD = 1'b0;
  localparam logic       KIND_STATUS  = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_CRC_ERR = 2'd1;
  localparam logic [1:0] ST_LEN_ERR = 2'd2;

  localparam logic [7:0] CFG_START_BYTE  = 8'd0;
  localparam logic [7:0] CFG_MAX_PAYLOAD = 8'd1;

  typedef struct packed {
    logic       kind;
    logic [7:0] cmd_code;
    logic [7:0] frame_len;
    logic [7:0] byte_index;
    logic [7:0] data_byte;
    logic [1:0] status;
  } res_t;

  function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC_MSB) != 8'd0) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

/* rtl/crc8_frame_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crc8_frame_checker
// Framed byte receiver: start byte, command, length, payload, CRC-8 check.
// ----------------------------------------------------------------------------
// Takes one received byte per cycle. Each byte is handled by the frame state
// machine and CRC-8 update in the cycle it is accepted; any result lands in
// an output register backed by one skid entry, so the input stalls only when
// both are full. Payload bytes come out with kind 0 and their index; the end
// of a frame gives kind 1 with status ok, CRC error or length error.
// Configuration writes are always ready and should be made between frames.
module crc8_frame_checker
  import crc8fc_pkg::*;
(
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  output logic       in_stall,
  input  wire  [7:0] in_rx_byte,
  output logic       out_valid,
  input  wire        out_stall,
  output logic       out_kind,
  output logic [7:0] out_cmd_code,
  output logic [7:0] out_frame_len,
  output logic [7:0] out_byte_index,
  output logic [7:0] out_data_byte,
  output logic [1:0] out_status,
  input  wire        cfg_valid,
  output logic       cfg_ready,
  input  wire  [7:0] cfg_index,
  input  wire  [7:0] cfg_data
);

  localparam logic [2:0] PH_HUNT    = 3'd0;
  localparam logic [2:0] PH_CMD     = 3'd1;
  localparam logic [2:0] PH_LEN     = 3'd2;
  localparam logic [2:0] PH_PAYLOAD = 3'd3;
  localparam logic [2:0] PH_CHECK   = 3'd4;

  logic [7:0] start_r;
  logic [7:0] max_r;
  logic [2:0] phase_r, phase_nxt;
  logic [7:0] cmd_r, cmd_nxt;
  logic [7:0] len_r, len_nxt;
  logic [7:0] cnt_r, cnt_nxt;
  logic [7:0] crc_r, crc_nxt;
  logic       accept;
  logic       res_vld;
  res_t       res;
  res_t       out_res;
  logic       full;

  assign cfg_ready = 1'b1;
  assign in_stall  = full;
  assign accept    = in_valid & ~full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= 8'hAA;
      max_r   <= 8'hFF;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_START_BYTE) begin
        start_r <= cfg_data;
      end else if (cfg_index == CFG_MAX_PAYLOAD) begin
        max_r <= cfg_data;
      end
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    cmd_nxt   = cmd_r;
    len_nxt   = len_r;
    cnt_nxt   = cnt_r;
    crc_nxt   = crc_r;
    res_vld   = 1'b0;
    res       = '0;
    if (accept) begin
      unique case (phase_r)
        PH_CMD: begin
          cmd_nxt   = in_rx_byte;
          crc_nxt   = crc8_next(crc_r, in_rx_byte);
          phase_nxt = PH_LEN;
        end
        PH_LEN: begin
          len_nxt = in_rx_byte;
          crc_nxt = crc8_next(crc_r, in_rx_byte);
          cnt_nxt = 8'd0;
          if (in_rx_byte > max_r) begin
            res_vld       = 1'b1;
            res.kind      = KIND_STATUS;
            res.cmd_code  = cmd_r;
            res.frame_len = in_rx_byte;
            res.status    = ST_LEN_ERR;
            phase_nxt     = PH_HUNT;
          end else begin
            phase_nxt = (in_rx_byte == 8'd0) ? PH_CHECK : PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          res_vld        = 1'b1;
          res.kind       = KIND_PAYLOAD;
          res.cmd_code   = cmd_r;
          res.frame_len  = len_r;
          res.byte_index = cnt_r;
          res.data_byte  = in_rx_byte;
          res.status     = ST_OK;
          crc_nxt        = crc8_next(crc_r, in_rx_byte);
          cnt_nxt        = cnt_r + 8'd1;
          if (cnt_nxt == len_r) begin
            phase_nxt = PH_CHECK;
          end
        end
        PH_CHECK: begin
          res_vld       = 1'b1;
          res.kind      = KIND_STATUS;
          res.cmd_code  = cmd_r;
          res.frame_len = len_r;
          res.status    = (in_rx_byte == crc_r) ? ST_OK : ST_CRC_ERR;
          phase_nxt     = PH_HUNT;
        end
        default: begin
          if (in_rx_byte == start_r) begin
            crc_nxt   = 8'd0;
            cnt_nxt   = 8'd0;
            phase_nxt = PH_CMD;
          end else begin
            phase_nxt = PH_HUNT;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      cmd_r   <= 8'd0;
      len_r   <= 8'd0;
      cnt_r   <= 8'd0;
      crc_r   <= 8'd0;
    end else begin
      phase_r <= phase_nxt;
      cmd_r   <= cmd_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
      crc_r   <= crc_nxt;
    end
  end

  crc8fc_out_stage u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (res_vld),
    .push_res (res),
    .full     (full),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_res  (out_res)
  );

  assign out_kind       = out_res.kind;
  assign out_cmd_code   = out_res.cmd_code;
  assign out_frame_len  = out_res.frame_len;
  assign out_byte_index = out_res.byte_index;
  assign out_data_byte  = out_res.data_byte;
  assign out_status     = out_res.status;

  a_stall_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with empty output register");

  a_status_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == KIND_STATUS) |->
      (out_byte_index == 8'd0 && out_data_byte == 8'd0))
    else $error("status item carries payload fields");

  a_payload_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == KIND_PAYLOAD) |->
      (out_byte_index < out_frame_len && out_status == ST_OK))
    else $error("payload item index out of frame");

  a_phase_legal: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r <= PH_CHECK)
    else $error("frame phase left its code range");

endmodule
`default_nettype wire

/* rtl/crc8fc_out_stage.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crc8fc_out_stage
// Output register with one skid entry; full flag throttles the input side.
// ----------------------------------------------------------------------------
module crc8fc_out_stage
  import crc8fc_pkg::*;
(
  input  wire  clk,
  input  wire  rst_n,
  input  wire  push,
  input  res_t push_res,
  output logic full,
  output logic out_valid,
  input  wire  out_stall,
  output res_t out_res
);

  logic main_vld_r;
  logic skid_vld_r;
  res_t main_r;
  res_t skid_r;
  logic pop;

  assign pop       = main_vld_r & ~out_stall;
  assign full      = skid_vld_r;
  assign out_valid = main_vld_r;
  assign out_res   = main_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (!main_vld_r || pop) begin
      main_vld_r <= skid_vld_r | push;
      skid_vld_r <= 1'b0;
    end else if (push) begin
      skid_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!main_vld_r || pop) begin
      main_r <= skid_vld_r ? skid_r : push_res;
    end else if (push) begin
      skid_r <= push_res;
    end
  end

endmodule
`default_nettype wire
